// File: rtl/core/wbrid_pkg.sv
// Shared types and constants of the beacon Remote ID parser.
package wbrid_pkg;

  localparam int unsigned HdrFixedBytes = 36;
  localparam int unsigned FcsBytes      = 4;
  localparam int unsigned MinFrameBytes = 40;
  localparam int unsigned AddrFirstPos  = 10;
  localparam int unsigned AddrLastPos   = 15;
  localparam int unsigned PosMax        = 4095;

  localparam logic [7:0] IdSsid      = 8'h00;
  localparam logic [7:0] IdVendor    = 8'hDD;
  localparam logic [7:0] VendorType  = 8'h0D;
  localparam logic [7:0] Oui0        = 8'hFA;
  localparam logic [7:0] Oui1        = 8'h0B;
  localparam logic [7:0] Oui2        = 8'hBC;
  localparam logic [7:0] PrintLow    = 8'h20;
  localparam logic [7:0] PrintEnd    = 8'h7F;
  localparam logic [7:0] SubstChar   = 8'h2E;
  localparam logic [1:0] FcTypeMgmt  = 2'd0;
  localparam logic [3:0] SubBeacon   = 4'd8;
  localparam logic [3:0] SubProbeRsp = 4'd5;
  localparam logic [7:0] VendorHdrLen = 8'd4;

  typedef struct packed {
    logic [7:0]        frame_byte;
    logic [11:0]       frame_length;
    logic              is_mgmt_packet;
    logic signed [7:0] signal_strength;
    logic [3:0]        radio_channel;
    logic              end_of_frame;
  } wbrid_in_t;

  typedef struct packed {
    logic [47:0]       source_address;
    logic signed [7:0] signal_level;
    logic [3:0]        channel_number;
    logic              remote_id_seen;
    logic [5:0]        name_length;
    logic [7:0]        name_char;
    logic [31:0]       accepted_count;
    logic [31:0]       packets_count;
    logic              last_of_run;
  } wbrid_out_t;

  // Per-frame summary handed from the walker to the drain side.
  typedef struct packed {
    logic              bank;
    logic [47:0]       address;
    logic signed [7:0] level;
    logic [3:0]        channel;
    logic              rid_hit;
    logic [5:0]        name_count;
    logic [31:0]       accepted;
    logic [31:0]       offered;
  } wbrid_sum_t;

  // Expected vendor body byte: OUI then type.
  function automatic logic [7:0] vendor_byte(logic [1:0] k);
    logic [7:0] v;
    unique case (k)
      2'd0:    v = Oui0;
      2'd1:    v = Oui1;
      2'd2:    v = Oui2;
      default: v = VendorType;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] sanitise(logic [7:0] b);
    return (b >= PrintLow && b < PrintEnd) ? b : SubstChar;
  endfunction

endpackage

// File: rtl/core/wbrid_walker.sv
// Per-byte frame classification, address latch and tagged element walk.
module wbrid_walker import wbrid_pkg::*; #(
  parameter int unsigned NAME_MAX = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   fire_i,
  input  wbrid_in_t                              in_i,
  output logic                                   wr_en_o,
  output logic [((NAME_MAX > 1) ? $clog2(NAME_MAX) : 1):0] wr_addr_o,
  output logic [7:0]                             wr_data_o,
  output logic                                   sum_valid_o,
  output wbrid_sum_t                             sum_o
);

  localparam int unsigned IdxW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

  typedef enum logic [1:0] {
    PH_ID,
    PH_LEN,
    PH_BODY
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [11:0]       pos_q, pos_d;
  logic              rej_q, rej_d;
  logic              stop_q, stop_d;
  logic [7:0]        eid_q, eid_d;
  logic [7:0]        remain_q, remain_d;
  logic [7:0]        body_q, body_d;
  logic              vmatch_q, vmatch_d;
  logic [5:0]        ncnt_q, ncnt_d;
  logic              rid_q, rid_d;
  logic [47:0]       addr_q, addr_d;
  logic signed [7:0] level_q, level_d;
  logic [3:0]        chan_q, chan_d;
  logic [31:0]       acc_q, acc_d;
  logic [31:0]       off_q, off_d;
  logic              bank_q, bank_d;

  logic [7:0]  b;
  logic [11:0] flen;
  logic [11:0] ie_end;
  logic        walk;
  logic        fresh_rej;
  logic        frame_ok;
  logic [12:0] elem_end;

  assign b    = in_i.frame_byte;
  assign flen = in_i.frame_length;
  assign ie_end = (flen >= 12'(FcsBytes)) ? flen - 12'(FcsBytes) : 12'd0;
  assign elem_end = {1'b0, pos_q} + 13'd1 + {5'b0, b};
  assign fresh_rej = !in_i.is_mgmt_packet || flen < 12'(MinFrameBytes) ||
                     b[3:2] != FcTypeMgmt || (b[7:4] != SubBeacon && b[7:4] != SubProbeRsp);

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    rej_d     = rej_q;
    stop_d    = stop_q;
    eid_d     = eid_q;
    remain_d  = remain_q;
    body_d    = body_q;
    vmatch_d  = vmatch_q;
    ncnt_d    = ncnt_q;
    rid_d     = rid_q;
    addr_d    = addr_q;
    level_d   = level_q;
    chan_d    = chan_q;
    acc_d     = acc_q;
    off_d     = off_q;
    bank_d    = bank_q;
    wr_en_o   = 1'b0;
    wr_addr_o = {bank_q, body_q[IdxW-1:0]};
    wr_data_o = sanitise(b);
    sum_valid_o = 1'b0;
    frame_ok  = 1'b0;
    walk      = 1'b0;

    if (fire_i) begin
      // First byte: classify and clear per-frame state.
      if (pos_q == 12'd0) begin
        rej_d    = fresh_rej;
        stop_d   = 1'b0;
        phase_d  = PH_ID;
        eid_d    = '0;
        remain_d = '0;
        body_d   = '0;
        vmatch_d = 1'b0;
        ncnt_d   = '0;
        rid_d    = 1'b0;
        addr_d   = '0;
        level_d  = in_i.signal_strength;
        chan_d   = in_i.radio_channel;
      end

      if (!rej_d && pos_q >= 12'(AddrFirstPos) && pos_q <= 12'(AddrLastPos)) begin
        addr_d = {addr_q[39:0], b};
      end

      walk = !rej_d && !stop_q && pos_q >= 12'(HdrFixedBytes) && pos_q < ie_end;
      if (walk) begin
        unique case (phase_q)
          PH_ID: begin
            eid_d   = b;
            phase_d = PH_LEN;
          end
          PH_LEN: begin
            if (elem_end > {1'b0, ie_end}) begin
              stop_d = 1'b1;
            end else begin
              remain_d = b;
              body_d   = '0;
              vmatch_d = (eid_q == IdVendor) && (b >= VendorHdrLen);
              if (eid_q == IdSsid) begin
                ncnt_d = (b < 8'(NAME_MAX)) ? b[5:0] : 6'(NAME_MAX);
              end
              phase_d = (b == 8'd0) ? PH_ID : PH_BODY;
            end
          end
          default: begin
            if (eid_q == IdSsid) begin
              wr_en_o = body_q < 8'(NAME_MAX);
            end else if (vmatch_q && body_q < VendorHdrLen) begin
              if (b != vendor_byte(body_q[1:0])) begin
                vmatch_d = 1'b0;
              end else if (body_q[1:0] == 2'd3) begin
                rid_d = 1'b1;
              end
            end
            body_d   = body_q + 8'd1;
            remain_d = remain_q - 8'd1;
            if (remain_q == 8'd1) begin
              phase_d = PH_ID;
            end
          end
        endcase
      end

      if (in_i.end_of_frame) begin
        off_d = off_q + 32'd1;
        pos_d = '0;
        frame_ok = !rej_d && ({1'b0, pos_q} + 13'd1 == {1'b0, flen});
        if (frame_ok) begin
          acc_d       = acc_q + 32'd1;
          sum_valid_o = 1'b1;
          // The drain reads this bank; the next frame writes the other.
          bank_d      = ~bank_q;
        end
      end else begin
        pos_d = (pos_q == 12'(PosMax)) ? pos_q : pos_q + 12'd1;
      end
    end
  end

  always_comb begin
    sum_o.bank       = bank_q;
    sum_o.address    = addr_d;
    sum_o.level      = level_d;
    sum_o.channel    = chan_d;
    sum_o.rid_hit    = rid_d;
    sum_o.name_count = ncnt_d;
    sum_o.accepted   = acc_d;
    sum_o.offered    = off_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_ID;
      pos_q    <= '0;
      rej_q    <= 1'b0;
      stop_q   <= 1'b0;
      eid_q    <= '0;
      remain_q <= '0;
      body_q   <= '0;
      vmatch_q <= 1'b0;
      ncnt_q   <= '0;
      rid_q    <= 1'b0;
      addr_q   <= '0;
      level_q  <= '0;
      chan_q   <= '0;
      acc_q    <= '0;
      off_q    <= '0;
      bank_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      rej_q    <= rej_d;
      stop_q   <= stop_d;
      eid_q    <= eid_d;
      remain_q <= remain_d;
      body_q   <= body_d;
      vmatch_q <= vmatch_d;
      ncnt_q   <= ncnt_d;
      rid_q    <= rid_d;
      addr_q   <= addr_d;
      level_q  <= level_d;
      chan_q   <= chan_d;
      acc_q    <= acc_d;
      off_q    <= off_d;
      bank_q   <= bank_d;
    end
  end

endmodule

// File: rtl/core/wbrid_drain.sv
// Double-banked SSID store and the result drain with its output register.
module wbrid_drain import wbrid_pkg::*; #(
  parameter int unsigned NAME_MAX = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   wr_en_i,
  input  logic [((NAME_MAX > 1) ? $clog2(NAME_MAX) : 1):0] wr_addr_i,
  input  logic [7:0]                             wr_data_i,
  input  logic                                   sum_valid_i,
  input  wbrid_sum_t                             sum_i,
  output logic                                   busy_o,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output wbrid_out_t                             out_o
);

  localparam int unsigned IdxW  = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
  localparam int unsigned Depth = 2 * (1 << IdxW);

  logic [7:0]  mem [Depth];
  logic [7:0]  rdata_q;
  wbrid_sum_t  sum_q;
  logic [5:0]  rd_idx_q;
  logic [5:0]  cnt_q;
  logic        s1_valid_q;
  logic        s1_last_q;
  logic        out_valid_q;
  wbrid_out_t  out_q;

  logic issuing;
  logic out_ready;
  logic move;
  logic rd_en;

  assign issuing   = rd_idx_q != cnt_q;
  assign out_ready = !out_valid_q || !out_stall_i;
  assign move      = s1_valid_q && out_ready;
  assign rd_en     = issuing && (!s1_valid_q || move);
  assign busy_o    = issuing || s1_valid_q;

  // Writer and reader always sit on opposite banks.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en) begin
      rdata_q <= mem[{sum_q.bank, rd_idx_q[IdxW-1:0]}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q    <= '0;
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sum_valid_i) begin
        rd_idx_q <= '0;
        cnt_q    <= (sum_i.name_count == 6'd0) ? 6'd1 : sum_i.name_count;
      end else if (rd_en) begin
        rd_idx_q <= rd_idx_q + 6'd1;
      end
      if (rd_en) begin
        s1_valid_q <= 1'b1;
        s1_last_q  <= (rd_idx_q + 6'd1) == cnt_q;
      end else if (move) begin
        s1_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Snapshot only changes while idle, so it still matches the read in flight.
  always_ff @(posedge clk_i) begin
    if (sum_valid_i) begin
      sum_q <= sum_i;
    end
    if (move) begin
      out_q.source_address <= sum_q.address;
      out_q.signal_level   <= sum_q.level;
      out_q.channel_number <= sum_q.channel;
      out_q.remote_id_seen <= sum_q.rid_hit;
      out_q.name_length    <= sum_q.name_count;
      out_q.name_char      <= (sum_q.name_count == 6'd0) ? 8'd0 : rdata_q;
      out_q.accepted_count <= sum_q.accepted;
      out_q.packets_count  <= sum_q.offered;
      out_q.last_of_run    <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: rtl/core/wifi_beacon_remote_id_parser_unit.sv
// Beacon and probe-response element parser with Remote ID detection.
//
// Input channel: one frame byte per word with the frame length, the
// management class, signal level and channel, and an end-of-frame mark.
// Output channel: one word per kept SSID character (or a single word when
// no SSID was kept) after the final byte of an accepted frame; the last
// word of a frame carries last_of_run.
// Throughput: one input byte per cycle while no final byte is held;
// results leave at one per cycle while the receiver does not stall.
// The SSID lives in a two-bank memory: one bank fills with the frame being
// received while the other is read out for the previous frame, so the
// next frame streams in during the read-out. The final byte of a frame is
// held (in_stall_o) only while the previous frame's results are still
// being read from the memory: when the output side stalls, or when a frame
// shorter than that read-out follows.
// A receiver stall holds the output word and backs up into the read-out.
// Reset clears the counters, the walk state and the output valid; the
// SSID memory needs no clearing since only bytes written in the current
// frame are read.
module wifi_beacon_remote_id_parser_unit import wbrid_pkg::*; #(
  parameter int unsigned NAME_MAX = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  wbrid_in_t  in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output wbrid_out_t out_o
);

  localparam int unsigned IdxW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

  logic            fire;
  logic            busy;
  logic            wr_en;
  logic [IdxW:0]   wr_addr;
  logic [7:0]      wr_data;
  logic            sum_valid;
  wbrid_sum_t      sum;

  assign in_stall_o = busy && in_valid_i && in_i.end_of_frame;
  assign fire       = in_valid_i && !in_stall_o;

  wbrid_walker #(
    .NAME_MAX (NAME_MAX)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .in_i        (in_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .sum_valid_o (sum_valid),
    .sum_o       (sum)
  );

  wbrid_drain #(
    .NAME_MAX (NAME_MAX)
  ) u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .sum_valid_i (sum_valid),
    .sum_i       (sum),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

// File: rtl/core/wbrid_checker.sv
// Port-level checks for the parser, bound to the top level.
module wbrid_checker import wbrid_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input wbrid_in_t  in_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input wbrid_out_t out_o
);

  // Stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result word changed");

  // Only a final byte is ever held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_i && in_i.end_of_frame)
    else $error("input held on a byte that is not final");

  // A frame without SSID gives one word, blank character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.name_length == 6'd0 |-> out_o.last_of_run && out_o.name_char == 8'd0)
    else $error("empty name result malformed");

  // Words of one frame leave back to back while the receiver takes them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_o.last_of_run |=> out_valid_o)
    else $error("gap inside a result run");

endmodule

bind wifi_beacon_remote_id_parser_unit wbrid_checker u_wbrid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);
